>>> design/hierarchical_timer_wheel_top_assert.svh
// Assertion macros for the timing wheel checker
`ifndef HIERARCHICAL_TIMER_WHEEL_TOP_ASSERT_SVH
`define HIERARCHICAL_TIMER_WHEEL_TOP_ASSERT_SVH

// same-cycle implication, quiet during reset
`define HTW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define HTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds through reset
`define HTW_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/htw_pkg.sv
// Shared types and constants of the timing wheel
`timescale 1ns / 1ps
package htw_pkg;

  localparam int TIMER_ID_W  = 6;
  localparam int DELAY_W     = 32;
  localparam int CALL_W      = 32;
  localparam int LINK_W      = 7;
  localparam int SLACK_SHIFT = 8;   // slack is delay / 256

  // end-of-list marker in head, tail and link fields
  localparam logic [LINK_W-1:0] NIL = 7'd127;

  localparam logic RES_EXPIRY = 1'b0;
  localparam logic RES_ACK    = 1'b1;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_DEL  = 3'd1,
    OP_MOD  = 3'd2,
    OP_MODP = 3'd3,
    OP_TICK = 3'd4
  } op_code_t;

  typedef struct packed {
    logic [2:0]            operation;
    logic [TIMER_ID_W-1:0] timer_id;
    logic [DELAY_W-1:0]    delay;
  } in_item_t;

  typedef struct packed {
    logic                  result_kind;
    logic [TIMER_ID_W-1:0] expired_id;
    logic                  was_pending;
    logic [CALL_W-1:0]     fire_tick;
    logic                  last;
  } out_item_t;

  // field write enables of the timer memory
  typedef struct packed {
    logic nxt_en;
    logic prv_en;
    logic exp_en;
    logic home_en;
  } tm_we_t;

  // field write enables of the slot memory
  typedef struct packed {
    logic head_en;
    logic tail_en;
  } sm_we_t;

endpackage

>>> design/htw_slot_mem.sv
// Slot memory: head and tail of each wheel slot list
`timescale 1ns / 1ps
module htw_slot_mem import htw_pkg::*; #(
  parameter int NSLOTS = 512,
  parameter int SLOT_W = 9
) (
  input  logic              clk,
  input  logic [SLOT_W-1:0] rd_addr,
  output logic [LINK_W-1:0] rd_head,
  output logic [LINK_W-1:0] rd_tail,
  input  logic [SLOT_W-1:0] wr_addr,
  input  sm_we_t            we,
  input  logic [LINK_W-1:0] wr_head,
  input  logic [LINK_W-1:0] wr_tail
);

  typedef struct packed {
    logic [LINK_W-1:0] head;
    logic [LINK_W-1:0] tail;
  } slot_t;

  slot_t mem [NSLOTS];

  // per-field write, registered read
  always_ff @(posedge clk) begin
    if (we.head_en) begin
      mem[wr_addr].head <= wr_head;
    end
    if (we.tail_en) begin
      mem[wr_addr].tail <= wr_tail;
    end
    rd_head <= mem[rd_addr].head;
    rd_tail <= mem[rd_addr].tail;
  end

endmodule

>>> design/htw_timer_mem.sv
// Timer memory: list links, expiry and home slot of each timer
`timescale 1ns / 1ps
module htw_timer_mem import htw_pkg::*; #(
  parameter int NUM_TIMERS = 64,
  parameter int TIME_BITS  = 32,
  parameter int SLOT_W     = 9,
  parameter int ID_W       = 6
) (
  input  logic                 clk,
  input  logic [ID_W-1:0]      rd_addr,
  output logic [LINK_W-1:0]    rd_nxt,
  output logic [LINK_W-1:0]    rd_prv,
  output logic [TIME_BITS-1:0] rd_exp,
  output logic [SLOT_W-1:0]    rd_home,
  input  logic [ID_W-1:0]      wr_addr,
  input  tm_we_t               we,
  input  logic [LINK_W-1:0]    wr_nxt,
  input  logic [LINK_W-1:0]    wr_prv,
  input  logic [TIME_BITS-1:0] wr_exp,
  input  logic [SLOT_W-1:0]    wr_home
);

  typedef struct packed {
    logic [LINK_W-1:0]    nxt;
    logic [LINK_W-1:0]    prv;
    logic [TIME_BITS-1:0] exp;
    logic [SLOT_W-1:0]    home;
  } entry_t;

  entry_t mem [NUM_TIMERS];

  // per-field write, registered read
  always_ff @(posedge clk) begin
    if (we.nxt_en) begin
      mem[wr_addr].nxt <= wr_nxt;
    end
    if (we.prv_en) begin
      mem[wr_addr].prv <= wr_prv;
    end
    if (we.exp_en) begin
      mem[wr_addr].exp <= wr_exp;
    end
    if (we.home_en) begin
      mem[wr_addr].home <= wr_home;
    end
    rd_nxt  <= mem[rd_addr].nxt;
    rd_prv  <= mem[rd_addr].prv;
    rd_exp  <= mem[rd_addr].exp;
    rd_home <= mem[rd_addr].home;
  end

endmodule

>>> design/htw_slot_sel.sv
// Slot selection: wheel slot for an expiry, and slot of a cascading level
`timescale 1ns / 1ps
module htw_slot_sel import htw_pkg::*; #(
  parameter int TIME_BITS  = 32,
  parameter int ROOT_BITS  = 8,
  parameter int LEVEL_BITS = 6,
  parameter int SLOT_W     = 9
) (
  input  logic [TIME_BITS-1:0] cur_time,
  input  logic [TIME_BITS-1:0] expiry,
  input  logic [1:0]           casc_lvl,
  output logic [SLOT_W-1:0]    place_slot,
  output logic [SLOT_W-1:0]    casc_slot,
  output logic                 casc_idx_zero
);

  localparam int WW         = TIME_BITS + ROOT_BITS + 4 * LEVEL_BITS;
  localparam int ROOT_SLOTS = 1 << ROOT_BITS;
  localparam int LVL_SLOTS  = 1 << LEVEL_BITS;
  localparam logic [WW-1:0] TMASK = {{(WW-TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};
  localparam logic [WW-1:0] LIM1  = WW'(1) << (ROOT_BITS + LEVEL_BITS);
  localparam logic [WW-1:0] LIM2  = WW'(1) << (ROOT_BITS + 2 * LEVEL_BITS);
  localparam logic [WW-1:0] LIM3  = WW'(1) << (ROOT_BITS + 3 * LEVEL_BITS);
  localparam logic [WW-1:0] TOP   = WW'(1) << (ROOT_BITS + 4 * LEVEL_BITS);

  logic [TIME_BITS-1:0]  span;
  logic [WW-1:0]         d_w, e_w, c_w, clamp_w, l5_w, cshift_w;
  logic [LEVEL_BITS-1:0] cidx;

  assign span    = expiry - cur_time;
  assign d_w     = WW'(span);
  assign e_w     = WW'(expiry);
  assign c_w     = WW'(cur_time);
  // beyond the last level: select by the furthest expiry it covers
  assign clamp_w = (c_w + TOP - WW'(1)) & TMASK;
  assign l5_w    = (d_w >= TOP) ? clamp_w : e_w;

  // level by distance; past expiries go to the current root slot
  always_comb begin
    priority if (span[TIME_BITS-1]) begin
      place_slot = SLOT_W'(cur_time[ROOT_BITS-1:0]);
    end else if (d_w < WW'(ROOT_SLOTS)) begin
      place_slot = SLOT_W'(expiry[ROOT_BITS-1:0]);
    end else if (d_w < LIM1) begin
      place_slot = SLOT_W'(ROOT_SLOTS)
                 + SLOT_W'(LEVEL_BITS'(e_w >> ROOT_BITS));
    end else if (d_w < LIM2) begin
      place_slot = SLOT_W'(ROOT_SLOTS + LVL_SLOTS)
                 + SLOT_W'(LEVEL_BITS'(e_w >> (ROOT_BITS + LEVEL_BITS)));
    end else if (d_w < LIM3) begin
      place_slot = SLOT_W'(ROOT_SLOTS + 2 * LVL_SLOTS)
                 + SLOT_W'(LEVEL_BITS'(e_w >> (ROOT_BITS + 2 * LEVEL_BITS)));
    end else begin
      place_slot = SLOT_W'(ROOT_SLOTS + 3 * LVL_SLOTS)
                 + SLOT_W'(LEVEL_BITS'(l5_w >> (ROOT_BITS + 3 * LEVEL_BITS)));
    end
  end

  // current slot of a higher level during a cascade
  always_comb begin
    unique case (casc_lvl)
      2'd0:    cshift_w = c_w >> ROOT_BITS;
      2'd1:    cshift_w = c_w >> (ROOT_BITS + LEVEL_BITS);
      2'd2:    cshift_w = c_w >> (ROOT_BITS + 2 * LEVEL_BITS);
      default: cshift_w = c_w >> (ROOT_BITS + 3 * LEVEL_BITS);
    endcase
  end

  assign cidx          = LEVEL_BITS'(cshift_w);
  assign casc_idx_zero = (cidx == '0);
  assign casc_slot     = SLOT_W'(ROOT_SLOTS) + SLOT_W'({casc_lvl, cidx});

endmodule

>>> design/hierarchical_timer_wheel_top.sv
// Top level of the hierarchical timing wheel: command sequencer and time base
//
// Usage: an item (operation, timer_id, delay) is taken at a clock edge with start high
// and busy low. Add, delete, modify and modify-if-pending answer with one
// acknowledgement (result_kind 1, last 1) carrying the pending flag, 1 for modify. A tick
// may cascade the higher levels, then emits one expiry result per timer of the
// current root slot in list order, last set on the final one; a tick that
// expires nothing gives no result. Each result stands on out_item for one
// cycle with out_valid high; the receiver must take it then.
// An item runs through S_CMD_RD, S_CMD_LIM, S_CMD_RND and S_CMD_DEC, then as needed
// through S_UNL_A and S_UNL_B to unlink a pending timer and S_PL_0 to S_PL_2 to place
// it, then S_ACK; a spare code or an out-of-range id goes straight to S_ACK.
// A tick holds busy through any cascade of the higher levels, the re-placing of each
// timer moved by a cascade, and the expiry run over the current root slot.
// One item at a time: busy is low again while an acknowledgement stands, and
// in the cycle after the final expiry result.
// Reset: current time and pending flags clear at once; the slot memory is then
// cleared one slot per cycle (2^ROOT_BITS + 4 * 2^LEVEL_BITS slots, 512 by
// default) with busy high.
`timescale 1ns / 1ps
module hierarchical_timer_wheel_top import htw_pkg::*; #(
  parameter int NUM_TIMERS = 64,
  parameter int ROOT_BITS  = 8,
  parameter int LEVEL_BITS = 6,
  parameter int TIME_BITS  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int ID_W        = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int NSLOTS      = (1 << ROOT_BITS) + 4 * (1 << LEVEL_BITS);
  localparam int SLOT_W      = $clog2(NSLOTS);
  localparam int GUARD_W     = $clog2(NUM_TIMERS + 1);
  localparam int SMEAR_STEPS = $clog2(TIME_BITS);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_CMD_RD, S_CMD_LIM, S_CMD_RND, S_CMD_DEC,
    S_UNL_A, S_UNL_B, S_PL_0, S_PL_1, S_PL_2, S_ACK, S_TICK,
    S_CAS_RD, S_CAS_HD, S_CAS_NX, S_CAS_TM,
    S_EXP_RD, S_EXP_HD, S_EXP_NX, S_EXP_TM
  } state_t;

  state_t                 state_r;
  logic [SLOT_W-1:0]      clr_r;
  logic [TIME_BITS-1:0]   cur_time_r;
  logic [NUM_TIMERS-1:0]  pending_r;
  logic [2:0]             op_r;
  logic [TIMER_ID_W-1:0]  id_r;
  logic [TIME_BITS-1:0]   delta_r, e_r, slack_r, lim_r, old_exp_r, pe_r, call_r;
  logic [LINK_W-1:0]      p_r, n_r, tail_r, head_r, nxt_r;
  logic [SLOT_W-1:0]      h_r, s_r, cs_r;
  logic                   ret_r, pl_cas_r, unl_place_r, cz_r;
  logic [ID_W-1:0]        pid_r;
  logic [GUARD_W-1:0]     guard_r;
  logic [1:0]             lvl_r;
  logic [ROOT_BITS-1:0]   ri_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  // memory ports
  logic [ID_W-1:0]      tm_raddr, tm_waddr;
  tm_we_t               tm_we;
  logic [LINK_W-1:0]    tm_wnxt, tm_wprv, tm_rd_nxt, tm_rd_prv;
  logic [TIME_BITS-1:0] tm_wexp, tm_rd_exp;
  logic [SLOT_W-1:0]    tm_whome, tm_rd_home;
  logic [SLOT_W-1:0]    sm_raddr, sm_waddr;
  sm_we_t               sm_we;
  logic [LINK_W-1:0]    sm_whead, sm_wtail, sm_rd_head, sm_rd_tail;

  logic [SLOT_W-1:0]    place_slot, casc_slot;
  logic                 casc_idx_zero;
  logic                 id_ok, cmd_pend, list_end, exp_last;
  logic [TIME_BITS-1:0] smear, rounded;

  htw_timer_mem #(
    .NUM_TIMERS (NUM_TIMERS),
    .TIME_BITS  (TIME_BITS),
    .SLOT_W     (SLOT_W),
    .ID_W       (ID_W)
  ) u_timer_mem (
    .clk     (clk),
    .rd_addr (tm_raddr),
    .rd_nxt  (tm_rd_nxt),
    .rd_prv  (tm_rd_prv),
    .rd_exp  (tm_rd_exp),
    .rd_home (tm_rd_home),
    .wr_addr (tm_waddr),
    .we      (tm_we),
    .wr_nxt  (tm_wnxt),
    .wr_prv  (tm_wprv),
    .wr_exp  (tm_wexp),
    .wr_home (tm_whome)
  );

  htw_slot_mem #(
    .NSLOTS (NSLOTS),
    .SLOT_W (SLOT_W)
  ) u_slot_mem (
    .clk     (clk),
    .rd_addr (sm_raddr),
    .rd_head (sm_rd_head),
    .rd_tail (sm_rd_tail),
    .wr_addr (sm_waddr),
    .we      (sm_we),
    .wr_head (sm_whead),
    .wr_tail (sm_wtail)
  );

  htw_slot_sel #(
    .TIME_BITS  (TIME_BITS),
    .ROOT_BITS  (ROOT_BITS),
    .LEVEL_BITS (LEVEL_BITS),
    .SLOT_W     (SLOT_W)
  ) u_slot_sel (
    .cur_time      (cur_time_r),
    .expiry        (pe_r),
    .casc_lvl      (lvl_r),
    .place_slot    (place_slot),
    .casc_slot     (casc_slot),
    .casc_idx_zero (casc_idx_zero)
  );

  assign id_ok    = (in_item.timer_id < NUM_TIMERS);
  assign cmd_pend = pending_r[id_r[ID_W-1:0]];
  assign list_end = (head_r == NIL) || (guard_r == GUARD_W'(NUM_TIMERS));
  assign exp_last = (tm_rd_nxt == NIL) || (guard_r == GUARD_W'(NUM_TIMERS - 1));

  // slack rounding: clear every bit below the top bit that changed
  always_comb begin
    smear = e_r ^ lim_r;
    for (int k = 0; k < SMEAR_STEPS; k++) begin
      smear = smear | (smear >> (1 << k));
    end
  end
  assign rounded = lim_r & ~(smear >> 1);

  // memory addresses and writes per state
  always_comb begin
    tm_raddr = '0;
    tm_waddr = pid_r;
    tm_we    = '0;
    tm_wnxt  = NIL;
    tm_wprv  = NIL;
    tm_wexp  = pe_r;
    tm_whome = s_r;
    sm_raddr = '0;
    sm_waddr = s_r;
    sm_we    = '0;
    sm_whead = NIL;
    sm_wtail = NIL;
    unique case (state_r)
      S_CLR: begin
        sm_waddr = clr_r;
        sm_we    = '{head_en: 1'b1, tail_en: 1'b1};
      end
      S_CMD_RD: tm_raddr = id_r[ID_W-1:0];
      S_UNL_A: begin
        if (p_r == NIL) begin
          sm_waddr      = h_r;
          sm_we.head_en = 1'b1;
          sm_whead      = n_r;
        end else begin
          tm_waddr     = p_r[ID_W-1:0];
          tm_we.nxt_en = 1'b1;
          tm_wnxt      = n_r;
        end
      end
      S_UNL_B: begin
        if (n_r == NIL) begin
          sm_waddr      = h_r;
          sm_we.tail_en = 1'b1;
          sm_wtail      = p_r;
        end else begin
          tm_waddr     = n_r[ID_W-1:0];
          tm_we.prv_en = 1'b1;
          tm_wprv      = p_r;
        end
      end
      S_PL_0: begin
        tm_we.exp_en = 1'b1;
        sm_raddr     = place_slot;
      end
      S_PL_1: begin
        tm_we         = '{nxt_en: 1'b1, prv_en: 1'b1, exp_en: 1'b0, home_en: 1'b1};
        tm_wprv       = sm_rd_tail;
        sm_we.tail_en = 1'b1;
        sm_wtail      = LINK_W'(pid_r);
        if (sm_rd_tail == NIL) begin
          sm_we.head_en = 1'b1;
          sm_whead      = LINK_W'(pid_r);
        end
      end
      S_PL_2: begin
        if (tail_r != NIL) begin
          tm_waddr     = tail_r[ID_W-1:0];
          tm_we.nxt_en = 1'b1;
          tm_wnxt      = LINK_W'(pid_r);
        end
      end
      S_CAS_RD: sm_raddr = casc_slot;
      S_CAS_HD: begin
        sm_waddr = cs_r;
        sm_we    = '{head_en: 1'b1, tail_en: 1'b1};
      end
      S_CAS_NX, S_EXP_NX: tm_raddr = head_r[ID_W-1:0];
      S_EXP_RD: sm_raddr = SLOT_W'(ri_r);
      S_EXP_HD: begin
        sm_waddr = SLOT_W'(ri_r);
        sm_we    = '{head_en: 1'b1, tail_en: 1'b1};
      end
      default: ;
    endcase
  end

  // sequencer, time base, pending flags and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      cur_time_r  <= '0;
      pending_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == SLOT_W'(NSLOTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_r    <= in_item.operation;
            id_r    <= in_item.timer_id;
            delta_r <= TIME_BITS'(in_item.delay);
            if (in_item.operation == OP_TICK) begin
              state_r <= S_TICK;
            end else if (id_ok && in_item.operation <= OP_MODP) begin
              state_r <= S_CMD_RD;
            end else begin
              ret_r   <= id_ok && pending_r[in_item.timer_id[ID_W-1:0]];
              state_r <= S_ACK;
            end
          end
        end
        S_CMD_RD: begin
          e_r     <= cur_time_r + delta_r;
          slack_r <= delta_r >> SLACK_SHIFT;
          state_r <= S_CMD_LIM;
        end
        S_CMD_LIM: begin
          p_r       <= tm_rd_prv;
          n_r       <= tm_rd_nxt;
          h_r       <= tm_rd_home;
          old_exp_r <= tm_rd_exp;
          lim_r     <= e_r + slack_r;
          state_r   <= S_CMD_RND;
        end
        S_CMD_RND: begin
          e_r     <= rounded;
          state_r <= S_CMD_DEC;
        end
        S_CMD_DEC: begin
          pe_r        <= e_r;
          pid_r       <= id_r[ID_W-1:0];
          pl_cas_r    <= 1'b0;
          unl_place_r <= 1'b1;
          unique case (op_r)
            OP_ADD: begin
              ret_r   <= cmd_pend;
              state_r <= cmd_pend ? S_UNL_A : S_PL_0;
            end
            OP_DEL: begin
              ret_r       <= cmd_pend;
              unl_place_r <= 1'b0;
              state_r     <= cmd_pend ? S_UNL_A : S_ACK;
            end
            OP_MOD: begin
              ret_r <= 1'b1;
              if (cmd_pend && old_exp_r == e_r) begin
                state_r <= S_ACK;
              end else begin
                state_r <= cmd_pend ? S_UNL_A : S_PL_0;
              end
            end
            default: begin
              ret_r   <= cmd_pend;
              state_r <= cmd_pend ? S_UNL_A : S_ACK;
            end
          endcase
        end
        S_UNL_A: state_r <= S_UNL_B;
        S_UNL_B: begin
          pending_r[pid_r] <= 1'b0;
          state_r          <= unl_place_r ? S_PL_0 : S_ACK;
        end
        S_PL_0: begin
          s_r     <= place_slot;
          state_r <= S_PL_1;
        end
        S_PL_1: begin
          tail_r           <= sm_rd_tail;
          pending_r[pid_r] <= 1'b1;
          state_r          <= S_PL_2;
        end
        S_PL_2: begin
          if (pl_cas_r) begin
            head_r  <= nxt_r;
            guard_r <= guard_r + 1'b1;
            state_r <= S_CAS_NX;
          end else begin
            state_r <= S_ACK;
          end
        end
        S_ACK: begin
          out_valid_r <= 1'b1;
          out_r       <= '{result_kind: RES_ACK, expired_id: id_r, was_pending: ret_r,
                           fire_tick: '0, last: 1'b1};
          state_r     <= S_IDLE;
        end
        S_TICK: begin
          lvl_r   <= 2'd0;
          call_r  <= cur_time_r;
          ri_r    <= cur_time_r[ROOT_BITS-1:0];
          state_r <= (cur_time_r[ROOT_BITS-1:0] == '0) ? S_CAS_RD : S_EXP_RD;
        end
        // cascade: empty one higher slot and re-place its timers
        S_CAS_RD: begin
          cs_r    <= casc_slot;
          cz_r    <= casc_idx_zero;
          state_r <= S_CAS_HD;
        end
        S_CAS_HD: begin
          head_r  <= sm_rd_head;
          guard_r <= '0;
          state_r <= S_CAS_NX;
        end
        S_CAS_NX: begin
          if (list_end) begin
            if (cz_r && lvl_r != 2'd3) begin
              lvl_r   <= lvl_r + 1'b1;
              state_r <= S_CAS_RD;
            end else begin
              state_r <= S_EXP_RD;
            end
          end else begin
            state_r <= S_CAS_TM;
          end
        end
        S_CAS_TM: begin
          nxt_r    <= tm_rd_nxt;
          pe_r     <= tm_rd_exp;
          pid_r    <= head_r[ID_W-1:0];
          pl_cas_r <= 1'b1;
          state_r  <= S_PL_0;
        end
        // expiry run over the current root slot
        S_EXP_RD: state_r <= S_EXP_HD;
        S_EXP_HD: begin
          head_r     <= sm_rd_head;
          guard_r    <= '0;
          cur_time_r <= cur_time_r + 1'b1;
          state_r    <= S_EXP_NX;
        end
        S_EXP_NX: state_r <= list_end ? S_IDLE : S_EXP_TM;
        S_EXP_TM: begin
          out_valid_r                   <= 1'b1;
          out_r                         <= '{result_kind: RES_EXPIRY,
                                             expired_id: TIMER_ID_W'(head_r),
                                             was_pending: 1'b0,
                                             fire_tick: CALL_W'(call_r),
                                             last: exp_last};
          pending_r[head_r[ID_W-1:0]] <= 1'b0;
          head_r                        <= tm_rd_nxt;
          guard_r                       <= guard_r + 1'b1;
          state_r                       <= S_EXP_NX;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> design/htw_checker.sv
// Port-level checker for the timing wheel, bound to the top level
`timescale 1ns / 1ps
`include "hierarchical_timer_wheel_top_assert.svh"
module htw_checker import htw_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // no result straight after a reset cycle
  `HTW_ASSERT_ALWAYS(a_no_result_after_rst, !rst_n, !out_valid, "result right after reset")
  // an accepted item keeps the block busy
  `HTW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item but not busy")
  // acknowledgements are always the only result of their item
  `HTW_ASSERT_NOW(a_ack_last, out_valid && out_item.result_kind == RES_ACK, out_item.last, "ack without last")
  // after the final result no further result follows at once
  `HTW_ASSERT_NEXT(a_last_ends, out_valid && out_item.last, !out_valid, "result after last")
  // an unfinished expiry run holds busy
  `HTW_ASSERT_NEXT(a_run_busy, out_valid && !out_item.last, busy, "expiry run dropped busy")

endmodule

bind hierarchical_timer_wheel_top htw_checker u_htw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
